// ===== rtl/tnc_pkg.sv =====
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared sizes, character codes, types and helpers of the tag nesting checker.
// ----------------------------------------------------------------------------
package tnc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int NAME_LEN    = 16;

  localparam int CH_W   = 8;
  localparam int SD_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int NL_W   = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam int LEN_W  = $clog2(NAME_LEN + 1);
  localparam int POS_W  = $clog2(NAME_LEN + 2);
  localparam int ADDR_W = $clog2(STACK_DEPTH * NAME_LEN);

  localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_OUT,
    PH_START,
    PH_LEAD,
    PH_TOKEN,
    PH_AFTER,
    PH_CLOSE
  } tnc_phase_e;

  // Requests from the control path to the stack memories
  typedef struct packed {
    logic              name_we;
    logic [ADDR_W-1:0] name_waddr;
    logic [CH_W-1:0]   name_wdata;
    logic [ADDR_W-1:0] name_raddr;
    logic              len_we;
    logic [SD_W-1:0]   len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic [SD_W-1:0]   len_raddr;
  } tnc_mem_req_t;

  // Registered read data, valid in the cycle after the read address
  typedef struct packed {
    logic [CH_W-1:0]  name;
    logic [LEN_W-1:0] len;
  } tnc_mem_rsp_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== rtl/tnc_in_if.sv =====
// ----------------------------------------------------------------------------
// tnc_in_if
// Character channel: one character or an end-of-line marker per transaction.
// ----------------------------------------------------------------------------
interface tnc_in_if;
  logic                     valid;
  logic                     ready;
  logic [tnc_pkg::CH_W-1:0] ch;
  logic                     end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

// ===== rtl/tnc_out_if.sv =====
// ----------------------------------------------------------------------------
// tnc_out_if
// Verdict channel: one verdict per line.
// ----------------------------------------------------------------------------
interface tnc_out_if;
  logic valid;
  logic ready;
  logic legal;
  logic overflowed;

  modport source (output valid, output legal, output overflowed, input ready);
  modport sink   (input valid, input legal, input overflowed, output ready);
endinterface

// ===== rtl/tnc_stack_mem.sv =====
// ----------------------------------------------------------------------------
// tnc_stack_mem
// Name store and name length store of the tag stack, synchronous read with
// bypass of a write to the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module tnc_stack_mem (
  input  logic                  clk_i,
  input  tnc_pkg::tnc_mem_req_t mem_req_i,
  output tnc_pkg::tnc_mem_rsp_t mem_rsp_o
);

  logic [tnc_pkg::CH_W-1:0]  name_mem [tnc_pkg::STACK_DEPTH * tnc_pkg::NAME_LEN];
  logic [tnc_pkg::LEN_W-1:0] len_mem  [tnc_pkg::STACK_DEPTH];

  logic [tnc_pkg::CH_W-1:0]  name_rd_q;
  logic [tnc_pkg::LEN_W-1:0] len_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.name_we) begin
      name_mem[mem_req_i.name_waddr] <= mem_req_i.name_wdata;
    end
    if (mem_req_i.name_we && (mem_req_i.name_waddr == mem_req_i.name_raddr)) begin
      name_rd_q <= mem_req_i.name_wdata;
    end else begin
      name_rd_q <= name_mem[mem_req_i.name_raddr];
    end
  end

  // A push writes the length of the row that becomes the top: bypass it
  always_ff @(posedge clk_i) begin
    if (mem_req_i.len_we) begin
      len_mem[mem_req_i.len_waddr] <= mem_req_i.len_wdata;
    end
    if (mem_req_i.len_we && (mem_req_i.len_waddr == mem_req_i.len_raddr)) begin
      len_rd_q <= mem_req_i.len_wdata;
    end else begin
      len_rd_q <= len_mem[mem_req_i.len_raddr];
    end
  end

  assign mem_rsp_o.name = name_rd_q;
  assign mem_rsp_o.len  = len_rd_q;

endmodule

// ===== rtl/tnc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnc_ctrl
// Tag parser, stack pointer and verdict register. Reads the stack memories at
// the address of the next state so the data is ready for the next character.
// ----------------------------------------------------------------------------
module tnc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [tnc_pkg::CH_W-1:0] in_ch_i,
  input  logic                     in_eol_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output logic                     out_legal_o,
  output logic                     out_overflowed_o,
  input  logic                     out_ready_i,
  output tnc_pkg::tnc_mem_req_t    mem_req_o,
  input  tnc_pkg::tnc_mem_rsp_t    mem_rsp_i
);

  tnc_pkg::tnc_phase_e         phase_q, phase_d;
  logic [tnc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [tnc_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [tnc_pkg::POS_W-1:0]   tok_q, tok_d;
  logic                        slash_q, slash_d;
  logic                        mis_q, mis_d;
  logic                        failed_q, failed_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q;
  logic                        legal_q, overflowed_q;

  logic                        acc;
  logic                        verdict;
  logic                        tok_write;
  logic                        sp;
  logic [tnc_pkg::SD_W-1:0]    row_d;
  logic [tnc_pkg::NL_W-1:0]    col_d;
  logic [tnc_pkg::POS_W-1:0]   top_len;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign verdict    = acc && in_eol_i;
  assign sp         = tnc_pkg::is_space(in_ch_i);
  assign top_len    = tnc_pkg::POS_W'(mem_rsp_i.len);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    tok_d     = tok_q;
    slash_d   = slash_q;
    mis_d     = mis_q;
    failed_d  = failed_q;
    ovf_d     = ovf_q;
    tok_write = 1'b0;
    mem_req_o = '0;

    if (acc) begin
      if (in_eol_i) begin
        phase_d  = tnc_pkg::PH_OUT;
        cnt_d    = '0;
        pos_d    = '0;
        tok_d    = '0;
        slash_d  = 1'b0;
        mis_d    = 1'b0;
        failed_d = 1'b0;
        ovf_d    = 1'b0;
      end else if (!failed_q) begin
        if (phase_q == tnc_pkg::PH_OUT) begin
          if (in_ch_i == tnc_pkg::CH_LT) begin
            phase_d = tnc_pkg::PH_START;
            pos_d   = '0;
            tok_d   = '0;
            slash_d = 1'b0;
            mis_d   = 1'b0;
          end
        end else if (in_ch_i == tnc_pkg::CH_GT) begin
          phase_d = tnc_pkg::PH_OUT;
          if (phase_q == tnc_pkg::PH_CLOSE) begin
            if ((cnt_q == '0) || mis_q || (pos_q != top_len)) begin
              failed_d = 1'b1;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end else if ((phase_q != tnc_pkg::PH_START) && !slash_q) begin
            if ((cnt_q >= tnc_pkg::CNT_W'(tnc_pkg::STACK_DEPTH)) ||
                (tok_q > tnc_pkg::POS_W'(tnc_pkg::NAME_LEN))) begin
              ovf_d    = 1'b1;
              failed_d = 1'b1;
            end else begin
              // push: record the length of the new top
              mem_req_o.len_we    = 1'b1;
              mem_req_o.len_waddr = cnt_q[tnc_pkg::SD_W-1:0];
              mem_req_o.len_wdata = tok_q[tnc_pkg::LEN_W-1:0];
              cnt_d               = cnt_q + 1'b1;
            end
          end
        end else begin
          unique case (phase_q)
            tnc_pkg::PH_START: begin
              if (in_ch_i == tnc_pkg::CH_SLASH) begin
                phase_d = tnc_pkg::PH_CLOSE;
              end else if (sp) begin
                phase_d = tnc_pkg::PH_LEAD;
              end else begin
                phase_d   = tnc_pkg::PH_TOKEN;
                tok_write = 1'b1;
              end
            end
            tnc_pkg::PH_LEAD: begin
              if (!sp) begin
                phase_d   = tnc_pkg::PH_TOKEN;
                tok_write = 1'b1;
              end
            end
            tnc_pkg::PH_TOKEN: begin
              if (sp) begin
                phase_d = tnc_pkg::PH_AFTER;
              end else begin
                tok_write = 1'b1;
              end
            end
            tnc_pkg::PH_CLOSE: begin
              // compare against the top name, read out in the previous cycle
              if ((cnt_q == '0) || (pos_q >= tnc_pkg::POS_W'(tnc_pkg::NAME_LEN)) ||
                  (pos_q >= top_len) || (mem_rsp_i.name != in_ch_i)) begin
                mis_d = 1'b1;
              end
              if (pos_q <= tnc_pkg::POS_W'(tnc_pkg::NAME_LEN)) begin
                pos_d = pos_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
          slash_d = (in_ch_i == tnc_pkg::CH_SLASH);
        end
      end
    end

    if (tok_write) begin
      if ((cnt_q < tnc_pkg::CNT_W'(tnc_pkg::STACK_DEPTH)) &&
          (tok_q < tnc_pkg::POS_W'(tnc_pkg::NAME_LEN))) begin
        mem_req_o.name_we    = 1'b1;
        mem_req_o.name_waddr =
          tnc_pkg::ADDR_W'(tnc_pkg::ADDR_W'(cnt_q[tnc_pkg::SD_W-1:0]) *
                           tnc_pkg::ADDR_W'(tnc_pkg::NAME_LEN)) +
          tnc_pkg::ADDR_W'(tok_q[tnc_pkg::NL_W-1:0]);
        mem_req_o.name_wdata = in_ch_i;
      end
      if (tok_q <= tnc_pkg::POS_W'(tnc_pkg::NAME_LEN)) begin
        tok_d = tok_q + 1'b1;
      end
    end

    // prefetch the entry the next closing character will compare against
    row_d = (cnt_d == '0) ? '0 : tnc_pkg::SD_W'(cnt_d - 1'b1);
    col_d = (pos_d < tnc_pkg::POS_W'(tnc_pkg::NAME_LEN)) ? pos_d[tnc_pkg::NL_W-1:0] : '0;
    mem_req_o.name_raddr =
      tnc_pkg::ADDR_W'(tnc_pkg::ADDR_W'(row_d) * tnc_pkg::ADDR_W'(tnc_pkg::NAME_LEN)) +
      tnc_pkg::ADDR_W'(col_d);
    mem_req_o.len_raddr = row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tnc_pkg::PH_OUT;
      cnt_q       <= '0;
      pos_q       <= '0;
      tok_q       <= '0;
      slash_q     <= 1'b0;
      mis_q       <= 1'b0;
      failed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      tok_q    <= tok_d;
      slash_q  <= slash_d;
      mis_q    <= mis_d;
      failed_q <= failed_d;
      ovf_q    <= ovf_d;
      if (verdict) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict) begin
      legal_q      <= !failed_q && (cnt_q == '0);
      overflowed_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_legal_o      = legal_q;
  assign out_overflowed_o = overflowed_q;

endmodule

// ===== rtl/tag_nesting_checker.sv =====
// ----------------------------------------------------------------------------
// tag_nesting_checker
// Checks that the markup tags of a line nest properly, one character a cycle while input is not held off.
// ----------------------------------------------------------------------------
// Transactions on in_i, a character or an end-of-line marker each, may come
// back to back or with gaps. The stack of open tag names lives in a
// synchronous name memory and a length memory; each cycle the logic reads
// the entry that the next closing-tag character will compare against, so the
// read latency is hidden and the sustained rate is one character per cycle
// while input is not held off. The verdict of a line appears on out_o in the
// cycle after its end-of-line transaction and sits in an output register;
// input is held off only while that register is full and not being taken.
// The stores need no clearing after reset: only entries written on the
// current line are ever compared.
// ----------------------------------------------------------------------------
module tag_nesting_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  tnc_in_if.sink     in_i,
  tnc_out_if.source  out_o
);

  tnc_pkg::tnc_mem_req_t mem_req;
  tnc_pkg::tnc_mem_rsp_t mem_rsp;

  tnc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ch_i          (in_i.ch),
    .in_eol_i         (in_i.end_of_line),
    .in_ready_o       (in_i.ready),
    .out_valid_o      (out_o.valid),
    .out_legal_o      (out_o.legal),
    .out_overflowed_o (out_o.overflowed),
    .out_ready_i      (out_o.ready),
    .mem_req_o        (mem_req),
    .mem_rsp_i        (mem_rsp)
  );

  tnc_stack_mem u_stack_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp)
  );

endmodule

// ===== rtl/tnc_checker.sv =====
// ----------------------------------------------------------------------------
// tnc_checker
// Port-level checks of the tag nesting checker, bound to the top level.
// ----------------------------------------------------------------------------
module tnc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_eol_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_legal_i,
  input logic out_overflowed_i
);

  // A verdict is valid in the cycle after an accepted end-of-line transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_eol_i) |=> out_valid_i)
    else $error("no verdict after end of line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_eol_i))
    else $error("verdict without end of line");

  // An overflow always fails the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_legal_i && out_overflowed_i))
    else $error("overflowed line reported legal");

  // Hold input while an untaken verdict fills the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input taken while verdict stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_legal_i) && $stable(out_overflowed_i)))
    else $error("stalled verdict changed");

endmodule

bind tag_nesting_checker tnc_checker u_tnc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_eol_i         (in_i.end_of_line),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_legal_i      (out_o.legal),
  .out_overflowed_i (out_o.overflowed)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Line-by-line check of the tag nesting checker. Lines of characters and
// end-of-line markers go in, in bursts with gaps. A scoreboard tracks the
// open-tag stack of each line and predicts the verdict. Each verdict that
// comes out is compared with the oldest prediction. The verdict receiver
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
  import tnc_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic legal;
    logic overflowed;
  } verdict_t;

  typedef struct {
    logic [7:0] b[20];
    int         n;
  } gen_name_t;

  // Scoreboard: tracks the open-tag stack of the current line, queues verdicts
  class verdict_scoreboard;
    logic [7:0]  name_mem[STACK_DEPTH*NAME_LEN];
    int unsigned name_len[STACK_DEPTH];
    int unsigned depth;
    int unsigned close_pos;
    int unsigned tok_len;
    tnc_phase_e  phase;
    bit          slash_last;
    bit          mismatch;
    bit          failed;
    bit          ovf_seen;
    verdict_t    verdict_q[$];
    int          errors;

    function new();
      foreach (name_mem[i]) name_mem[i] = '0;
      foreach (name_len[i]) name_len[i] = 0;
      errors = 0;
      restart_line();
    endfunction

    static function bit blank_char(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function void restart_line();
      depth      = 0;
      phase      = PH_OUT;
      close_pos  = 0;
      tok_len    = 0;
      slash_last = 0;
      mismatch   = 0;
      failed     = 0;
      ovf_seen   = 0;
    endfunction

    function void push_token_byte(logic [7:0] c);
      if (depth < STACK_DEPTH && tok_len < NAME_LEN)
        name_mem[depth*NAME_LEN + tok_len] = c;
      if (tok_len <= NAME_LEN)
        tok_len++;
    endfunction

    function void compare_close_byte(logic [7:0] c);
      int unsigned top;
      if (depth == 0) begin
        mismatch = 1;
      end else begin
        top = depth - 1;
        if (close_pos >= NAME_LEN || close_pos >= name_len[top] ||
            name_mem[top*NAME_LEN + close_pos] != c)
          mismatch = 1;
      end
      if (close_pos <= NAME_LEN)
        close_pos++;
    endfunction

    function void end_tag();
      if (phase == PH_CLOSE) begin
        if (depth == 0 || mismatch || close_pos != name_len[depth-1])
          failed = 1;
        else
          depth--;
      end else if (phase != PH_START && !slash_last) begin
        if (depth >= STACK_DEPTH || tok_len > NAME_LEN) begin
          ovf_seen = 1;
          failed   = 1;
        end else begin
          name_len[depth] = tok_len;
          depth++;
        end
      end
      phase = PH_OUT;
    endfunction

    // Note an accepted input transaction; returns 0 when the block ignores it
    function bit note_input(logic [7:0] c, logic eol);
      if (eol) begin
        verdict_q.push_back('{legal: (!failed && depth == 0), overflowed: ovf_seen});
        restart_line();
        return 1;
      end
      if (failed)
        return 0;
      if (phase == PH_OUT) begin
        if (c == CH_LT) begin
          phase      = PH_START;
          close_pos  = 0;
          tok_len    = 0;
          slash_last = 0;
          mismatch   = 0;
        end
        return 1;
      end
      if (c == CH_GT) begin
        end_tag();
        return 1;
      end
      case (phase)
        PH_START: begin
          if (c == CH_SLASH) begin
            phase = PH_CLOSE;
          end else if (blank_char(c)) begin
            phase = PH_LEAD;
          end else begin
            phase = PH_TOKEN;
            push_token_byte(c);
          end
        end
        PH_LEAD: begin
          if (!blank_char(c)) begin
            phase = PH_TOKEN;
            push_token_byte(c);
          end
        end
        PH_TOKEN: begin
          if (blank_char(c))
            phase = PH_AFTER;
          else
            push_token_byte(c);
        end
        PH_CLOSE: compare_close_byte(c);
        default: ;
      endcase
      slash_last = (c == CH_SLASH);
      return 1;
    endfunction

    function void check_result(logic legal, logic overflowed);
      verdict_t exp_v;
      if (verdict_q.size() == 0) begin
        $error("verdict with no line pending: legal %0b overflowed %0b", legal, overflowed);
        errors++;
        return;
      end
      exp_v = verdict_q.pop_front();
      if (legal !== exp_v.legal) begin
        $error("legal: expected %0b, got %0b", exp_v.legal, legal);
        errors++;
      end
      if (overflowed !== exp_v.overflowed) begin
        $error("overflowed: expected %0b, got %0b", exp_v.overflowed, overflowed);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tnc_in_if  in_if();
  tnc_out_if out_if();

  tag_nesting_checker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  verdict_scoreboard sb = new();

  logic [7:0] line_buf[$];
  int         sent_items = 0;
  int         burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      void'(sb.note_input(in_if.ch, in_if.end_of_line));
      sent_items++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.legal, out_if.overflowed);
  end

  // Verdict receiver: switches among random stall modes, with two long hold-offs
  initial begin
    int cyc;
    int mode;
    int hold;
    cyc  = 0;
    mode = 0;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 600 || cyc == 2500)
        hold = 300;
      if (cyc % 50 == 0)
        mode = $urandom_range(0, 3);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (cyc % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one transaction; bursts of random length with random gaps between
  task automatic send_item(logic [7:0] c, logic eol);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.ch          <= c;
    in_if.end_of_line <= eol;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) != 0)
      return 8'(8'h61 + $urandom_range(0, 25));
    do b = 8'($urandom_range(0, 255));
    while (b == CH_GT || b == CH_SLASH || verdict_scoreboard::blank_char(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
  endfunction

  function automatic gen_name_t random_name(int min_len, int max_len);
    gen_name_t nm;
    nm.n = $urandom_range(min_len, max_len);
    for (int i = 0; i < nm.n; i++) nm.b[i] = name_byte();
    return nm;
  endfunction

  function automatic gen_name_t pick_name();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return random_name(0, 0);
    if (r < 75) return random_name(1, 6);
    if (r < 95) return random_name(7, 16);
    return random_name(17, 19);
  endfunction

  function automatic void emit_open(gen_name_t nm, bit plain);
    line_buf.push_back(CH_LT);
    // an empty name needs whitespace, or the tag is empty and ignored
    if (nm.n == 0 || (!plain && $urandom_range(0, 4) == 0))
      repeat ($urandom_range(1, 2)) line_buf.push_back(blank_byte());
    for (int i = 0; i < nm.n; i++) line_buf.push_back(nm.b[i]);
    if (!plain && $urandom_range(0, 9) < 3) begin
      line_buf.push_back(blank_byte());
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 5))
          0: line_buf.push_back("=");
          1: line_buf.push_back("\"");
          2: line_buf.push_back(CH_LT);
          default: line_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
        endcase
      end
      if ($urandom_range(0, 1)) line_buf.push_back(blank_byte());
    end
    line_buf.push_back(CH_GT);
  endfunction

  function automatic void emit_close(gen_name_t nm);
    line_buf.push_back(CH_LT);
    line_buf.push_back(CH_SLASH);
    for (int i = 0; i < nm.n; i++) line_buf.push_back(nm.b[i]);
    line_buf.push_back(CH_GT);
  endfunction

  function automatic void emit_self();
    gen_name_t nm;
    nm = random_name(1, 19);
    line_buf.push_back(CH_LT);
    for (int i = 0; i < nm.n; i++) line_buf.push_back(nm.b[i]);
    if ($urandom_range(0, 1)) line_buf.push_back(CH_SPACE);
    line_buf.push_back(CH_SLASH);
    line_buf.push_back(CH_GT);
  endfunction

  function automatic void emit_text();
    logic [7:0] b;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 3))
        0: b = CH_SPACE;
        1: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_LT);
        end
        default: b = 8'(8'h61 + $urandom_range(0, 25));
      endcase
      line_buf.push_back(b);
    end
  endfunction

  function automatic void build_nested();
    gen_name_t open_q[$];
    gen_name_t nm;
    int        max_d;
    int        r;
    max_d = $urandom_range(1, 5);
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (open_q.size() < max_d && r < 40) begin
        nm = pick_name();
        emit_open(nm, 1'b0);
        open_q.push_back(nm);
      end else if (open_q.size() > 0 && r < 75) begin
        emit_close(open_q.pop_back());
      end else if (r < 88) begin
        emit_text();
      end else begin
        emit_self();
      end
    end
    while (open_q.size() > 0) emit_close(open_q.pop_back());
  endfunction

  function automatic void build_deep(int levels);
    gen_name_t open_q[$];
    gen_name_t nm;
    repeat (levels) begin
      nm = random_name(1, 2);
      emit_open(nm, 1'b1);
      open_q.push_back(nm);
    end
    while (open_q.size() > 0) emit_close(open_q.pop_back());
  endfunction

  // Break a line: drop, overwrite or insert a few bytes
  function automatic void mutate_line();
    int idx;
    repeat ($urandom_range(1, 3)) begin
      if (line_buf.size() == 0) return;
      idx = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: line_buf.delete(idx);
        1: line_buf[idx] = 8'($urandom_range(0, 255));
        default: begin
          case ($urandom_range(0, 3))
            0: line_buf.insert(idx, CH_LT);
            1: line_buf.insert(idx, CH_GT);
            2: line_buf.insert(idx, CH_SLASH);
            default: line_buf.insert(idx, CH_SPACE);
          endcase
        end
      endcase
    end
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 30)) begin
      case ($urandom_range(0, 9))
        0, 1: line_buf.push_back(CH_LT);
        2, 3: line_buf.push_back(CH_GT);
        4:    line_buf.push_back(CH_SLASH);
        5:    line_buf.push_back(CH_SPACE);
        default: line_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin
    int r;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.ch          = '0;
    in_if.end_of_line = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines
    send_line();
    add_text("<a></a>");                  send_line();
    add_text("<>");                       send_line();
    add_text("<a");                       send_line();
    add_text("< >");                      send_line();
    add_text("< ></>");                   send_line();
    add_text("</>");                      send_line();
    add_text("<br/><br /><p>x</p>");      send_line();
    add_text("<a<b></a<b>");              send_line();
    add_text("</a>");                     send_line();
    add_text("<a></b>");                  send_line();
    add_text("<a><b></a></b>");           send_line();
    add_text("<a/ ></a/>");               send_line();
    add_text("<a></ a>");                 send_line();
    add_text("<abcdefghijklmnop></abcdefghijklmnop>");  send_line();
    add_text("<abcdefghijklmnop></abcdefghijklmnopq>"); send_line();
    add_text("<abcdefghijklmnopq>");      send_line();
    add_text("<abcdefghijklmnopq/>");     send_line();
    add_text("<a></x></a><b>");           send_line();
    add_text("hi > / there");             send_line();
    // tab, line feed, vertical tab, form feed and carriage return around and inside a tag
    line_buf = '{CH_LT, 8'h0B, "p", 8'h0C, "q", 8'h0D, CH_GT, CH_LT, CH_SLASH, "p", CH_GT};
    send_line();
    line_buf = '{CH_LT, "a", 8'h09, "x", 8'h0A, CH_GT, CH_LT, CH_SLASH, "a", CH_GT};
    send_line();
    // extreme byte values in names
    line_buf = '{CH_LT, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_GT,
                 CH_LT, CH_SLASH, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_GT};
    send_line();
    build_deep(STACK_DEPTH);     send_line();
    build_deep(STACK_DEPTH + 1); send_line();

    while (sent_items < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        build_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2));
      end else if (r < 18) begin
        build_noise();
      end else begin
        build_nested();
        if (r >= 70) mutate_line();
      end
      send_line();
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tnc_pkg.sv
rtl/tnc_in_if.sv
rtl/tnc_out_if.sv
rtl/tnc_stack_mem.sv
rtl/tnc_ctrl.sv
rtl/tag_nesting_checker.sv
rtl/tnc_checker.sv
verif/testbench.sv
